### rtl/core/mss_pkg.sv
// shared types, constants and helper functions for the seven-segment scanner
`timescale 1ns / 1ps
package mss_pkg;

	// field widths fixed by the item format
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned DIG_W   = 4;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned POS_W   = 3;

	// decimal digits held after conversion, enough for any 16-bit magnitude
	localparam int unsigned BCD_DIGITS = 5;
	localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
	localparam int unsigned CNT_W      = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BLANK   = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_value;
		logic step_conv;
		logic refresh;
		logic blank;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic conv_last;
	} dp_sts_t;

	// lit-segment pattern for a decimal digit (a=bit0 .. g=bit6)
	function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
		logic [SEG_W-1:0] pat;
		unique case (digit)
			4'd0: pat = 7'h3F;
			4'd1: pat = 7'h06;
			4'd2: pat = 7'h5B;
			4'd3: pat = 7'h4F;
			4'd4: pat = 7'h66;
			4'd5: pat = 7'h6D;
			4'd6: pat = 7'h7D;
			4'd7: pat = 7'h07;
			4'd8: pat = 7'h7F;
			4'd9: pat = 7'h6F;
			default: pat = 7'h00;
		endcase
		return pat;
	endfunction

	// add three to every decimal digit of five or more, ahead of a shift
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
		logic [BCD_W-1:0] res;
		res = bcd;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd[4*i +: 4] >= 4'd5) begin
				res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
			end
		end
		return res;
	endfunction

endpackage

### rtl/core/mss_if.sv
// request and response channel interfaces of the seven-segment scanner
`timescale 1ns / 1ps
interface mss_req_if;
	logic                       valid;
	logic                       ready;
	logic [mss_pkg::CMD_W-1:0]  cmd;
	logic signed [mss_pkg::VALUE_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mss_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [mss_pkg::DIG_W-1:0] digit_enable;
	logic [mss_pkg::SEG_W-1:0] segments_n;

	modport source (output valid, output digit_enable, output segments_n, input ready);
	modport sink   (input valid, input digit_enable, input segments_n, output ready);
endinterface

### rtl/core/multiplexed_seven_segment_scanner.sv
// Seven-segment scanner top level: one request in, one response out.
// Set value: response valid once the request is taken and a 16-step bit-serial conversion has run.
// Refresh, blank or unused code: response valid in the cycle after the request is taken.
// One request at a time: a new request is taken only after the response is accepted.
// Asynchronous reset clears the value to zero, scan to the first digit, digit lines low,
// segments off.
`timescale 1ns / 1ps
module multiplexed_seven_segment_scanner #(
	parameter int unsigned NUM_DIGITS = 4
) (
	input logic       clk,
	input logic       arst_n,
	mss_req_if.sink   req,
	mss_rsp_if.source rsp
);
	import mss_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// sequencing
	mss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_cmd    (dp_cmd),
		.dp_sts    (dp_sts)
	);

	// conversion and drive registers
	mss_dp #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (req.value),
		.dp_cmd       (dp_cmd),
		.dp_sts       (dp_sts),
		.digit_enable (rsp.digit_enable),
		.segments_n   (rsp.segments_n)
	);

endmodule

### rtl/core/mss_ctrl.sv
// controller state machine: request handshake, conversion sequencing, response
`timescale 1ns / 1ps
module mss_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [mss_pkg::CMD_W-1:0] req_cmd,
	output logic                      req_ready,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output mss_pkg::dp_cmd_t          dp_cmd,
	input  mss_pkg::dp_sts_t          dp_sts
);
	import mss_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   req_acc;

	assign req_acc = req_valid && req_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = (req_cmd == CMD_SET) ? ST_CONV : ST_RESP;
				end
			end
			ST_CONV: begin
				if (dp_sts.conv_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready         = 1'b0;
		rsp_valid         = 1'b0;
		dp_cmd.load_value = 1'b0;
		dp_cmd.step_conv  = 1'b0;
		dp_cmd.refresh    = 1'b0;
		dp_cmd.blank      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready         = 1'b1;
				dp_cmd.load_value = req_valid && (req_cmd == CMD_SET);
				dp_cmd.refresh    = req_valid && (req_cmd == CMD_REFRESH);
				dp_cmd.blank      = req_valid && (req_cmd == CMD_BLANK);
			end
			ST_CONV: begin
				dp_cmd.step_conv = 1'b1;
			end
			ST_RESP: begin
				rsp_valid = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// a set-value request always starts a conversion
	assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_cmd == CMD_SET) |=> state_q == ST_CONV)
		else $error("set-value request did not start conversion");

	// any other request is answered in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_cmd != CMD_SET) |=> rsp_valid)
		else $error("refresh or blank request not answered");

	// the last conversion step hands over to the response
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) && dp_sts.conv_last |=> rsp_valid)
		else $error("conversion end did not raise response");

	// one request at a time: no new request while a response is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("request taken while response pending");
`endif

endmodule

### rtl/core/mss_dp.sv
// datapath: magnitude, bit-serial decimal conversion, scan position and drive
`timescale 1ns / 1ps
module mss_dp #(
	parameter int unsigned NUM_DIGITS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [mss_pkg::VALUE_W-1:0]  value,
	input  mss_pkg::dp_cmd_t                    dp_cmd,
	output mss_pkg::dp_sts_t                    dp_sts,
	output logic [mss_pkg::DIG_W-1:0]           digit_enable,
	output logic [mss_pkg::SEG_W-1:0]           segments_n
);
	import mss_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(NUM_DIGITS - 1);
	localparam logic [7:0]       ALL_LINES = 8'((1 << NUM_DIGITS) - 1);

	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic [DIG_W-1:0]   dig_q;
	logic [SEG_W-1:0]   seg_q;

	logic [VALUE_W-1:0] mag;
	logic [POS_W-1:0]   pos_eff;
	logic [POS_W-1:0]   pos_next;
	logic [POS_W-1:0]   dig_idx;
	logic [3:0]         digit;
	logic [7:0]         onehot;
	logic [BCD_W-1:0]   bcd_adj;

	// magnitude of the signed value; the most negative value maps to 32768
	assign mag = value[VALUE_W-1] ? (~value + 1'b1) : value;

	// scan position, out-of-range positions read as position zero
	assign pos_eff  = (pos_q > LAST_POS) ? '0 : pos_q;
	assign pos_next = (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
	assign dig_idx  = LAST_POS - pos_eff;
	assign digit    = bcd_q[4*dig_idx +: 4];
	assign onehot   = 8'b1 << pos_eff;

	assign bcd_adj         = bcd_adjust(bcd_q);
	assign dp_sts.conv_last = (cnt_q == CNT_W'(VALUE_W - 1));

	// binary to decimal conversion, one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (dp_cmd.load_value) begin
			bin_q <= mag;
			bcd_q <= '0;
			cnt_q <= '0;
		end else if (dp_cmd.step_conv) begin
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// scan position and display drive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			dig_q <= '0;
			seg_q <= '1;
		end else if (dp_cmd.refresh) begin
			pos_q <= pos_next;
			dig_q <= onehot[DIG_W-1:0];
			seg_q <= ~seg_pattern(digit);
		end else if (dp_cmd.blank) begin
			dig_q <= ALL_LINES[DIG_W-1:0];
			seg_q <= '1;
		end
	end

	assign digit_enable = dig_q;
	assign segments_n   = seg_q;

endmodule
